@@ rtl/core/gregorian_day_difference_macros.svh @@
// Assertion macros used by the checker file of the day difference block.
// Depends on nothing; include by bare file name.
`ifndef GREGORIAN_DAY_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DAY_DIFFERENCE_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is high.
`define GDD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property on the rising clock edge, checked during reset as well.
`define GDD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/gdd_pkg.sv @@
// Package for the Gregorian day difference block: field widths, tdata layout,
// calendar tables and the lane/merge types. Depends on nothing.
`timescale 1ns / 1ps

package gdd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
   localparam int DNUM_W  = 23;   // day number of any 14-bit year fits unsigned
   localparam int DIFF_W  = 23;
   localparam int ORDER_W = 2;
   localparam int LEAP_W  = 13;   // leap days before a year below 16384

   localparam int YEAR_MAX = 9999;

   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 18;
   localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;
   localparam int MUL_W  = YEAR_W + RECIP_W;
   localparam int QUOT_W = 8;

   localparam int DAYS_PER_YEAR = 365;

   // request tdata layout, lowest bits first
   localparam int REQ_DATA_W = 48;
   localparam int REQ_FROM_LSB = 0;
   localparam int REQ_TO_LSB   = KEY_W;

   // response tdata layout, lowest bits first
   localparam int RSP_DATA_W    = 32;
   localparam int RSP_DIFF_LSB  = 0;
   localparam int RSP_ORDER_LSB = DIFF_W;
   localparam int RSP_FVAL_BIT  = DIFF_W + ORDER_W;
   localparam int RSP_TVAL_BIT  = DIFF_W + ORDER_W + 1;
   localparam int RSP_PAD_W     = RSP_DATA_W - DIFF_W - ORDER_W - 2;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef enum logic [ORDER_W-1:0] {
      ORDER_BEFORE = 2'd0,
      ORDER_EQUAL  = 2'd1,
      ORDER_AFTER  = 2'd2
   } order_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic [DNUM_W-1:0] day_num;
      logic [KEY_W-1:0]  key;     // {year, month, day} for ordering
      logic              valid;
   } lane_result_type;

   // month length in a common year; zero for codes that are not months
   function automatic logic [DAY_W-1:0] common_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the first of the month in a common year
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] days;
      case (m)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

@@ rtl/core/gdd_lane.sv @@
// One date lane: validity check and day number in three register stages.
// Depends on gdd_pkg.
`timescale 1ns / 1ps

module gdd_lane
   import gdd_pkg::*;
(
   input  logic            clock,
   input  logic            advance,
   input  date_type        date_in,
   output lane_result_type result
);

   // stage 1: divide year and leap-count year by 100
   logic [YEAR_W-1:0]  ly;
   logic [MUL_W-1:0]   prod_y, prod_ly;
   logic [YEAR_W-1:0]  y1_ff, ly1_ff;
   logic [MONTH_W-1:0] m1_ff;
   logic [DAY_W-1:0]   d1_ff;
   logic [QUOT_W-1:0]  qy1_ff, qly1_ff;
   logic [QUOT_W-1:0]  qy1_in, qly1_in;

   // January and February count leap days up to the year before
   assign ly      = (date_in.month <= MONTH_FEB) ? date_in.year - YEAR_W'(1) : date_in.year;
   assign prod_y  = MUL_W'(date_in.year) * MUL_W'(RECIP_100);
   assign prod_ly = MUL_W'(ly) * MUL_W'(RECIP_100);
   assign qy1_in  = prod_y[RECIP_SHIFT +: QUOT_W];
   assign qly1_in = prod_ly[RECIP_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      if (advance) begin
         y1_ff   <= date_in.year;
         m1_ff   <= date_in.month;
         d1_ff   <= date_in.day;
         ly1_ff  <= ly;
         qy1_ff  <= qy1_in;
         qly1_ff <= qly1_in;
      end
   end

   // stage 2: leap rule, validity, partial day number, leap count
   logic [YEAR_W-1:0]  rem100;
   logic               leap;
   logic [DAY_W-1:0]   mlen;
   logic               valid2_in, valid2_ff;
   logic [DNUM_W-1:0]  part2_in, part2_ff;
   logic [LEAP_W-1:0]  leaps2_in, leaps2_ff;
   logic [KEY_W-1:0]   key2_ff, key3_ff;

   assign rem100 = y1_ff - YEAR_W'(qy1_ff) * YEAR_W'(100);
   assign leap   = (y1_ff[1:0] == 2'b00 && rem100 != '0)
                || (rem100 == '0 && qy1_ff[1:0] == 2'b00);
   assign mlen   = (m1_ff == MONTH_FEB && leap) ? 5'd29 : common_len(m1_ff);

   assign valid2_in = (y1_ff != '0) && (32'(y1_ff) <= 32'(YEAR_MAX))
                   && (m1_ff >= MONTH_JAN) && (m1_ff <= MONTH_DEC)
                   && (d1_ff != '0) && (d1_ff <= mlen);

   assign part2_in  = DNUM_W'(y1_ff) * DNUM_W'(DAYS_PER_YEAR)
                    + DNUM_W'(days_before(m1_ff)) + DNUM_W'(d1_ff);
   assign leaps2_in = LEAP_W'(ly1_ff >> 2) - LEAP_W'(qly1_ff) + LEAP_W'(qly1_ff >> 2);

   always_ff @(posedge clock) begin
      if (advance) begin
         valid2_ff <= valid2_in;
         part2_ff  <= part2_in;
         leaps2_ff <= leaps2_in;
         key2_ff   <= {y1_ff, m1_ff, d1_ff};
      end
   end

   // stage 3: add the leap days
   logic [DNUM_W-1:0] dnum3_ff, dnum3_in;
   logic              valid3_ff;

   assign dnum3_in = part2_ff + DNUM_W'(leaps2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         dnum3_ff  <= dnum3_in;
         valid3_ff <= valid2_ff;
         key3_ff   <= key2_ff;
      end
   end

   assign result.day_num = dnum3_ff;
   assign result.key     = key3_ff;
   assign result.valid   = valid3_ff;

endmodule

@@ rtl/core/gdd_merge.sv @@
// Merge stage: subtracts the two lane day numbers and orders the raw dates.
// Depends on gdd_pkg.
`timescale 1ns / 1ps

module gdd_merge
   import gdd_pkg::*;
(
   input  logic              clock,
   input  logic              advance,
   input  lane_result_type   from_lane,
   input  lane_result_type   to_lane,
   output logic [DIFF_W-1:0] day_difference,
   output order_type         order,
   output logic              from_valid,
   output logic              to_valid
);

   logic [DNUM_W:0]   wide_diff;
   logic [DIFF_W-1:0] diff_in, diff_ff;
   order_type         order_in, order_ff;
   logic              fval_ff, tval_ff;

   assign wide_diff = {1'b0, to_lane.day_num} - {1'b0, from_lane.day_num};
   // drop the difference when either date is not a real date
   assign diff_in   = (from_lane.valid && to_lane.valid) ? DIFF_W'(wide_diff) : '0;

   always_comb begin
      if (from_lane.key < to_lane.key) begin
         order_in = ORDER_BEFORE;
      end else if (from_lane.key == to_lane.key) begin
         order_in = ORDER_EQUAL;
      end else begin
         order_in = ORDER_AFTER;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff  <= diff_in;
         order_ff <= order_in;
         fval_ff  <= from_lane.valid;
         tval_ff  <= to_lane.valid;
      end
   end

   assign day_difference = diff_ff;
   assign order          = order_ff;
   assign from_valid     = fval_ff;
   assign to_valid       = tval_ff;

endmodule

@@ rtl/core/gregorian_day_difference.sv @@
// Top level of the Gregorian day difference block: two date lanes and a merge
// stage behind one stream handshake. Depends on gdd_pkg, gdd_lane, gdd_merge.
//
// Usage:
//   req_*: one item is a date pair (start date, end date). It is taken at a
//     rising edge where req_tvalid and req_tready are both high.
//   rsp_*: one item per request: signed day difference, order of the raw
//     dates and a validity flag per date. Invalid dates give difference zero.
//   Pipeline: an accepted item passes four register stages before
//     rsp_tvalid rises. The start and end lanes each take three stages
//     (divide by 100, leap rule and partial sum, final add); the merge stage
//     is the output register.
//   Throughput: one item per cycle unless the output stalls. The whole
//     pipeline advances on one enable, so req_tready is high whenever the
//     output register is empty or is being taken in the same cycle.
//   Stall: with rsp_tvalid high and rsp_tready low the pipeline holds, the
//     response stays put and req_tready falls.
//   Reset: synchronous and active high; it drops all items in flight.
`timescale 1ns / 1ps

module gregorian_day_difference
   import gdd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [13:0] from_year, [17:14] from_month, [22:18] from_day,
   // [36:23] to_year, [40:37] to_month, [45:41] to_day, [47:46] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [22:0] day_difference, [24:23] order, [25] from_valid, [26] to_valid,
   // [31:27] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // one enable for every stage: move when the output slot frees up
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // occupancy of the three lane stages and the output register
   logic [2:0] stage_valid_ff, stage_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign stage_valid_in = advance ? {stage_valid_ff[1:0], req_tvalid} : stage_valid_ff;
   assign rsp_valid_in   = advance ? stage_valid_ff[2] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // unpack the two dates
   date_type from_date, to_date;
   assign from_date = date_type'(req_tdata[REQ_FROM_LSB +: KEY_W]);
   assign to_date   = date_type'(req_tdata[REQ_TO_LSB +: KEY_W]);

   lane_result_type from_lane, to_lane;

   gdd_lane u_from_lane (
      .clock   (clock),
      .advance (advance),
      .date_in (from_date),
      .result  (from_lane)
   );

   gdd_lane u_to_lane (
      .clock   (clock),
      .advance (advance),
      .date_in (to_date),
      .result  (to_lane)
   );

   logic [DIFF_W-1:0] day_difference;
   order_type         order;
   logic              from_valid, to_valid;

   gdd_merge u_merge (
      .clock          (clock),
      .advance        (advance),
      .from_lane      (from_lane),
      .to_lane        (to_lane),
      .day_difference (day_difference),
      .order          (order),
      .from_valid     (from_valid),
      .to_valid       (to_valid)
   );

   // pack the response item
   assign rsp_tdata = {RSP_PAD_W'(0), to_valid, from_valid, order, day_difference};

endmodule

@@ rtl/core/gdd_checker.sv @@
// Port checker for the Gregorian day difference block, bound to the top level.
// Depends on gdd_pkg and gregorian_day_difference_macros.svh.
`timescale 1ns / 1ps
`include "gregorian_day_difference_macros.svh"

module gdd_checker
   import gdd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [DIFF_W-1:0]  diff;
   logic [ORDER_W-1:0] ord;
   logic               both_valid;

   assign diff       = rsp_tdata[RSP_DIFF_LSB +: DIFF_W];
   assign ord        = rsp_tdata[RSP_ORDER_LSB +: ORDER_W];
   assign both_valid = rsp_tdata[RSP_FVAL_BIT] && rsp_tdata[RSP_TVAL_BIT];

   `GDD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response item changed while stalled")
   `GDD_ASSERT(a_order_code, clock, reset, rsp_tvalid |-> ord != 2'd3, "order field holds an unused code")
   `GDD_ASSERT(a_invalid_zero, clock, reset, rsp_tvalid && !both_valid |-> diff == '0, "invalid date pair gave a nonzero difference")
   `GDD_ASSERT(a_equal_zero, clock, reset, rsp_tvalid && ord == ORDER_EQUAL |-> diff == '0, "equal dates gave a nonzero difference")
   `GDD_ASSERT(a_before_pos, clock, reset, rsp_tvalid && both_valid && ord == ORDER_BEFORE |-> !diff[DIFF_W-1] && diff != '0, "earlier start date gave a difference that is not positive")

endmodule

bind gregorian_day_difference gdd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/testbench.sv @@
// Self-checking bench for gregorian_day_difference: streams date pairs in,
// predicts day difference, order and validity per pair, and checks every item.
// Depends on gdd_pkg and the gregorian_day_difference RTL.
`timescale 1ns / 1ps

module testbench;
   import gdd_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int CYCLE_LIMIT = 250000;
   localparam int MAX_IDLE    = 16;
   localparam int HOLD_CYCLES = 90;

   // expected response item for one date pair
   typedef struct {
      logic signed [DIFF_W-1:0] days;
      order_type                ord;
      logic                     from_ok;
      logic                     to_ok;
   } day_gap_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [13:0] from_year, [17:14] from_month, [22:18] from_day,
   // [36:23] to_year, [40:37] to_month, [45:41] to_day, [47:46] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [22:0] day_difference, [24:23] order, [25] from_valid, [26] to_valid,
   // [31:27] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   day_gap_type expected_gaps[$];
   int       mismatch_count = 0;
   int       cycle_count = 0;
   bit       tx_idle_on = 1'b1;
   bit       rx_idle_on = 1'b1;
   int       rx_hold_cycles = 0;

   gregorian_day_difference dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // ---------------------------------------------------------------- calendar

   function automatic bit year_is_leap(input int y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   // length of a month 1..12; February depends on the leap flag
   function automatic int month_length(input bit leap, input int m);
      int len;
      case (m)
         2:             len = leap ? 29 : 28;
         4, 6, 9, 11:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   function automatic bit date_is_real(input date_type dt);
      if (dt.year < 1 || dt.year > YEAR_MAX || dt.month < MONTH_JAN || dt.month > MONTH_DEC)
         return 1'b0;
      return dt.day >= 1 && dt.day <= month_length(year_is_leap(dt.year), dt.month);
   endfunction

   // Count days from a fixed origin. Leap days are counted through the year
   // before for January and February, so sum months with February at 28.
   function automatic int days_since_epoch(input date_type dt);
      int y;
      int prior;
      int total;
      y     = dt.year;
      prior = (dt.month <= MONTH_FEB) ? y - 1 : y;
      total = 365 * y + prior / 4 - prior / 100 + prior / 400 + dt.day;
      for (int m = 1; m < dt.month; m++)
         total += month_length(1'b0, m);
      return total;
   endfunction

   function automatic day_gap_type predict_gap(input date_type from_date,
                                                input date_type to_date);
      day_gap_type res;
      int       span;
      res.from_ok = date_is_real(from_date);
      res.to_ok   = date_is_real(to_date);
      span        = 0;
      // zero the difference unless both dates are real
      if (res.from_ok && res.to_ok)
         span = days_since_epoch(to_date) - days_since_epoch(from_date);
      res.days = span[DIFF_W-1:0];
      // order compares raw fields: year, then month, then day
      if (from_date.year != to_date.year)
         res.ord = (from_date.year < to_date.year) ? ORDER_BEFORE : ORDER_AFTER;
      else if (from_date.month != to_date.month)
         res.ord = (from_date.month < to_date.month) ? ORDER_BEFORE : ORDER_AFTER;
      else if (from_date.day != to_date.day)
         res.ord = (from_date.day < to_date.day) ? ORDER_BEFORE : ORDER_AFTER;
      else
         res.ord = ORDER_EQUAL;
      return res;
   endfunction

   function automatic date_type make_date(input int y, input int m, input int d);
      date_type dt;
      dt.year  = YEAR_W'(y);
      dt.month = MONTH_W'(m);
      dt.day   = DAY_W'(d);
      return dt;
   endfunction

   function automatic date_type random_real_date(input int lo_year, input int hi_year);
      int y;
      int m;
      y = $urandom_range(hi_year, lo_year);
      m = $urandom_range(12, 1);
      return make_date(y, m, $urandom_range(month_length(year_is_leap(y), m), 1));
   endfunction

   // Draw a real date near a century or leap boundary, about half the time near a month end.
   function automatic date_type boundary_date(input int base_year);
      int y;
      int m;
      int len;
      int d;
      y = base_year;
      if (y < 1) y = 1;
      if (y > YEAR_MAX) y = YEAR_MAX;
      case ($urandom_range(3, 0))
         0:       m = 1;
         1:       m = 2;
         2:       m = 3;
         default: m = $urandom_range(12, 1);
      endcase
      len = month_length(year_is_leap(y), m);
      d   = $urandom_range(1, 0) ? len - $urandom_range(2, 0) : $urandom_range(len, 1);
      return make_date(y, m, d);
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one date pair after a random gap; keep tvalid high when no gap is drawn.
   task automatic send_pair(input date_type from_date, input date_type to_date);
      int gap;
      gap = tx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 2 * KEY_W){1'b0}}, to_date, from_date};
      do @(posedge clock); while (!req_tready);
      expected_gaps.push_back(predict_gap(from_date, to_date));
   endtask

   task automatic send_dates(input int fy, input int fm, input int fd,
                             input int ty, input int tm, input int td);
      send_pair(make_date(fy, fm, fd), make_date(ty, tm, td));
   endtask

   // Drop tvalid and hold until every outstanding item has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_gaps.size() != 0) @(posedge clock);
   endtask

   // Cycle through all four idle combinations, one per block of 100 items.
   task automatic pick_idle_mode(input int index);
      tx_idle_on = ((index / 100) % 4) inside {1, 3};
      rx_idle_on = ((index / 100) % 4) >= 2;
   endtask

   // Receiver: stall a random number of cycles before each item, or a long
   // hold when one is requested.
   initial begin : response_sink
      int stall;
      wait (!reset);
      forever begin
         if (rx_hold_cycles > 0) begin
            stall          = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            stall = rx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Check every accepted response item against the oldest expectation.
   always @(posedge clock) begin : response_check
      day_gap_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_gaps.size() == 0) begin
            $error("response item with nothing expected: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_gaps.pop_front();
            if (rsp_tdata[RSP_DIFF_LSB +: DIFF_W] !== want.days) begin
               $error("day_difference: expected %0d, actual %0d", want.days,
                      $signed(rsp_tdata[RSP_DIFF_LSB +: DIFF_W]));
               mismatch_count++;
            end
            if (rsp_tdata[RSP_ORDER_LSB +: ORDER_W] !== want.ord) begin
               $error("order: expected %0d, actual %0d", want.ord,
                      rsp_tdata[RSP_ORDER_LSB +: ORDER_W]);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_FVAL_BIT] !== want.from_ok) begin
               $error("from_valid: expected %0b, actual %0b", want.from_ok,
                      rsp_tdata[RSP_FVAL_BIT]);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_TVAL_BIT] !== want.to_ok) begin
               $error("to_valid: expected %0b, actual %0b", want.to_ok,
                      rsp_tdata[RSP_TVAL_BIT]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Field extremes, leap rules and each kind of invalid date.
   task automatic test_directed_dates();
      send_dates(1, 1, 1, 9999, 12, 31);       // widest real span
      send_dates(9999, 12, 31, 1, 1, 1);       // same span, negative
      send_dates(2024, 3, 15, 2024, 3, 15);    // equal dates
      send_dates(2000, 2, 28, 2000, 3, 1);     // leap by the 400 rule
      send_dates(1900, 2, 28, 1900, 3, 1);     // century, not leap
      send_dates(2000, 2, 29, 2001, 2, 28);
      send_dates(1900, 2, 29, 1900, 3, 1);     // leap day in a common century
      send_dates(2023, 2, 29, 2023, 3, 1);     // leap day in a common year
      send_dates(2024, 2, 29, 2024, 2, 29);
      send_dates(2100, 2, 29, 2400, 2, 29);
      send_dates(0, 1, 1, 1, 1, 1);            // year zero
      send_dates(10000, 1, 1, 9999, 12, 31);   // above the year bound
      send_dates(16383, 15, 31, 0, 0, 0);      // all ones against all zeros
      send_dates(0, 0, 0, 0, 0, 0);
      send_dates(2000, 13, 1, 2000, 12, 31);   // month past December
      send_dates(2000, 0, 5, 2000, 1, 5);      // month zero
      send_dates(2000, 5, 0, 2000, 5, 1);      // day zero
      send_dates(2021, 4, 31, 2021, 4, 30);    // day past a 30-day month
      send_dates(1999, 12, 31, 2000, 1, 1);
      send_dates(5000, 14, 3, 5000, 14, 9);    // invalid both, ordered by day
      send_dates(1, 1, 1, 1, 3, 1);            // January of the first year
      send_dates(4, 2, 29, 4, 3, 1);           // first leap day
      send_dates(9999, 12, 31, 9999, 1, 1);
      wait_for_drain();
   endtask

   // Real date pairs anywhere in the year range.
   task automatic test_random_real_pairs();
      for (int i = 0; i < 550; i++) begin
         pick_idle_mode(i);
         send_pair(random_real_date(1, YEAR_MAX), random_real_date(1, YEAR_MAX));
      end
      wait_for_drain();
   endtask

   // Close pairs around century, leap and month-end boundaries.
   task automatic test_boundary_pairs();
      int base;
      for (int i = 0; i < 350; i++) begin
         pick_idle_mode(i);
         base = $urandom_range(100, 0) * 100 + $urandom_range(4, 0) - 2;
         send_pair(boundary_date(base), boundary_date(base + $urandom_range(4, 0) - 2));
      end
      wait_for_drain();
   endtask

   // Raw fields over their full widths, around the year bound as well.
   task automatic test_raw_fields();
      date_type from_date;
      date_type to_date;
      for (int i = 0; i < 350; i++) begin
         pick_idle_mode(i);
         from_date = date_type'(KEY_W'($urandom));
         to_date   = (i % 3 == 0) ? from_date : date_type'(KEY_W'($urandom));
         if (i % 5 == 0) begin
            from_date.year = YEAR_W'($urandom_range(YEAR_MAX + 10, YEAR_MAX - 10));
            to_date.year   = YEAR_W'($urandom_range(YEAR_MAX + 10, YEAR_MAX - 10));
         end
         if (i % 7 == 0)
            to_date.day = DAY_W'($urandom_range(31, 0));
         send_pair(from_date, to_date);
      end
      wait_for_drain();
   endtask

   // Hold the receiver off while items stream in back to back, so the
   // pipeline fills and req_tready falls.
   task automatic test_backpressure();
      tx_idle_on     = 1'b0;
      rx_idle_on     = 1'b1;
      rx_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 80; i++)
         send_pair(random_real_date(1, YEAR_MAX), random_real_date(1, YEAR_MAX));
      wait_for_drain();
      tx_idle_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_random_real_pairs();
      test_backpressure();
      test_boundary_pairs();
      test_raw_fields();
      // let the four-stage pipeline settle before the verdict
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ gregorian_day_difference.f @@
+incdir+rtl/core
rtl/core/gdd_pkg.sv
rtl/core/gdd_lane.sv
rtl/core/gdd_merge.sv
rtl/core/gregorian_day_difference.sv
rtl/core/gdd_checker.sv
bench/testbench.sv
